[rtl/core/pss_pkg.sv]
// ----------------------------------------------------------------------------
// PAM site scanner package
// Shared widths, reset values, register indexes, result types and the base
// and IUPAC decode functions used by the scanner modules.
// ----------------------------------------------------------------------------
package pss_pkg;

   // Field widths of the channels.
   localparam int CHAR_W      = 8;
   localparam int SEQ_W       = 16;
   localparam int POS_W       = 32;
   localparam int SITE_BITS_W = 64;
   localparam int GUIDE_LEN_W = 6;
   localparam int PAM_LEN_W   = 4;
   localparam int PAM_CODES_W = 64;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int BASE_W      = 3;

   // Default sizing of the window.
   localparam int MAX_GUIDE_DEF = 32;
   localparam int MAX_PAM_DEF   = 8;

   // Register reset values ("NGG" for the PAM).
   localparam logic [GUIDE_LEN_W-1:0] GUIDE_LEN_RST    = 6'd20;
   localparam logic [PAM_LEN_W-1:0]   PAM_LENGTH_RST   = 4'd3;
   localparam logic [PAM_CODES_W-1:0] PAM_CODES_RST    = 64'd4671310;
   localparam logic                   SCAN_MINUS_RST   = 1'b1;

   // Base code for anything that is not A, C, G or T.
   localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GUIDE_LEN    = 4'd0,
      CSR_PAM_LENGTH   = 4'd1,
      CSR_PAM_CODES    = 4'd2,
      CSR_SCAN_MINUS   = 4'd3
   } csr_index_type;

   // One found site, without the strand and framing flags.
   typedef struct packed {
      logic [SITE_BITS_W-1:0] bits;
      logic [SEQ_W-1:0]       seq_id;
      logic [POS_W-1:0]       position;
   } site_type;

   // Which strands matched for the current step.
   typedef struct packed {
      logic plus_hit;
      logic minus_hit;
   } hits_type;

   // ASCII base to 3-bit code (A, C, G, T as 0 to 3), anything else to BASE_OTHER.
   function automatic logic [BASE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
      logic [BASE_W-1:0] code;
      case (ch) inside
         "A", "a": code = 3'd0;
         "C", "c": code = 3'd1;
         "G", "g": code = 3'd2;
         "T", "t": code = 3'd3;
         default:  code = BASE_OTHER;
      endcase
      return code;
   endfunction

   // IUPAC code to base set: bit 0 A, bit 1 C, bit 2 G, bit 3 T.
   function automatic logic [3:0] code_mask(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] up;
      logic [3:0]        mask;
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      case (up)
         "N":     mask = 4'd15;
         "A":     mask = 4'd1;
         "C":     mask = 4'd2;
         "G":     mask = 4'd4;
         "T":     mask = 4'd8;
         "R":     mask = 4'd5;
         "Y":     mask = 4'd10;
         "S":     mask = 4'd6;
         "W":     mask = 4'd9;
         "K":     mask = 4'd12;
         "M":     mask = 4'd3;
         "B":     mask = 4'd14;
         "D":     mask = 4'd13;
         "H":     mask = 4'd11;
         "V":     mask = 4'd7;
         default: mask = 4'd0;
      endcase
      return mask;
   endfunction

   // Complement of a base set swaps A with T and C with G.
   function automatic logic [3:0] comp_mask(input logic [3:0] m);
      return {m[0], m[1], m[2], m[3]};
   endfunction

   // A base is in a set; N takes every base, including unknown ones.
   function automatic logic base_in(input logic [BASE_W-1:0] b, input logic [3:0] m);
      logic hit;
      if (m == 4'hF) begin
         hit = 1'b1;
      end else if (b[2]) begin
         hit = 1'b0;
      end else begin
         hit = m[b[1:0]];
      end
      return hit;
   endfunction

endpackage

[rtl/core/pss_if.sv]
// ----------------------------------------------------------------------------
// PAM site scanner channel interfaces
// Valid/ready channels for bases in, sites out and register writes.
// ----------------------------------------------------------------------------

// Base stream channel.
interface pss_req_if;
   logic                       valid;
   logic                       ready;
   logic [pss_pkg::CHAR_W-1:0] base_char;
   logic                       first_base;
   logic [pss_pkg::SEQ_W-1:0]  sequence_id;

   modport source (output valid, output base_char, output first_base,
                   output sequence_id, input ready);
   modport sink   (input valid, input base_char, input first_base,
                   input sequence_id, output ready);
endinterface

// Found site channel.
interface pss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pss_pkg::SITE_BITS_W-1:0] site_bits;
   logic [pss_pkg::SEQ_W-1:0]       site_sequence;
   logic [pss_pkg::POS_W-1:0]       site_position;
   logic                            minus_strand;
   logic                            last_site;

   modport source (output valid, output site_bits, output site_sequence,
                   output site_position, output minus_strand, output last_site,
                   input ready);
   modport sink   (input valid, input site_bits, input site_sequence,
                   input site_position, input minus_strand, input last_site,
                   output ready);
endinterface

// Register write channel.
interface pss_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pss_pkg::CSR_INDEX_W-1:0] index;
   logic [pss_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/pss_window.sv]
// ----------------------------------------------------------------------------
// PAM site scanner base window
// Shift register of decoded bases with fill count, base position counter
// and the step register that holds one accepted base for the matcher.
// ----------------------------------------------------------------------------
module pss_window #(
   parameter int MAX_GUIDE = pss_pkg::MAX_GUIDE_DEF,
   parameter int MAX_PAM   = pss_pkg::MAX_PAM_DEF,
   localparam int DEPTH    = MAX_GUIDE + MAX_PAM,
   localparam int FILL_W   = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [pss_pkg::CHAR_W-1:0]         base_char,
   input  logic                               first_base,
   input  logic [pss_pkg::SEQ_W-1:0]          sequence_id,
   input  logic                               advance,
   output logic                               step_valid,
   output logic [DEPTH-1:0][pss_pkg::BASE_W-1:0] win,
   output logic [FILL_W-1:0]                  fill,
   output logic [pss_pkg::SEQ_W-1:0]          seq_id,
   output logic [pss_pkg::POS_W-1:0]          position
);

   logic [DEPTH-1:0][pss_pkg::BASE_W-1:0] win_ff, win_in;
   logic [FILL_W-1:0]                     fill_ff, fill_in;
   logic [pss_pkg::POS_W-1:0]             index_ff, index_in;
   logic                                  valid_ff, valid_in;
   logic [pss_pkg::SEQ_W-1:0]             seq_ff, seq_in;
   logic [pss_pkg::POS_W-1:0]             pos_ff, pos_in;

   // Shift in a new base; a sequence start restarts the count and position.
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      index_in = index_ff;
      seq_in   = seq_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff & ~advance;
      if (load) begin
         win_in   = {win_ff[DEPTH-2:0], pss_pkg::base_code(base_char)};
         seq_in   = sequence_id;
         valid_in = 1'b1;
         if (first_base) begin
            fill_in  = FILL_W'(1);
            pos_in   = '0;
            index_in = pss_pkg::POS_W'(1);
         end else begin
            fill_in  = (fill_ff < FILL_W'(DEPTH)) ? fill_ff + FILL_W'(1) : fill_ff;
            pos_in   = index_ff;
            index_in = index_ff + pss_pkg::POS_W'(1);
         end
      end
   end

   // Window state and step valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= '0;
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   // Step payload.
   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      pos_ff <= pos_in;
   end

   assign step_valid = valid_ff;
   assign win        = win_ff;
   assign fill       = fill_ff;
   assign seq_id     = seq_ff;
   assign position   = pos_ff;

endmodule

[rtl/core/pss_match.sv]
// ----------------------------------------------------------------------------
// PAM site scanner matcher
// Checks the newest guide+PAM bases of the window for a plus strand and a
// minus strand site and packs the guide of each.
// ----------------------------------------------------------------------------
module pss_match #(
   parameter int MAX_GUIDE = pss_pkg::MAX_GUIDE_DEF,
   parameter int MAX_PAM   = pss_pkg::MAX_PAM_DEF,
   localparam int DEPTH    = MAX_GUIDE + MAX_PAM,
   localparam int FILL_W   = $clog2(DEPTH + 1)
) (
   input  logic [DEPTH-1:0][pss_pkg::BASE_W-1:0] win,
   input  logic [FILL_W-1:0]                  fill,
   input  logic [pss_pkg::SEQ_W-1:0]          seq_id,
   input  logic [pss_pkg::POS_W-1:0]          position,
   input  logic [pss_pkg::GUIDE_LEN_W-1:0]    guide_len,
   input  logic [pss_pkg::PAM_LEN_W-1:0]      pam_length,
   input  logic [pss_pkg::PAM_CODES_W-1:0]    pam_codes,
   input  logic                               scan_minus,
   output pss_pkg::hits_type                  hits,
   output pss_pkg::site_type                  plus_site,
   output pss_pkg::site_type                  minus_site
);

   logic [MAX_PAM-1:0][3:0]                pam_mask;
   logic [MAX_PAM-1:0][pss_pkg::BASE_W-1:0] pam_rev, plus_pam;
   logic [DEPTH-1:0][pss_pkg::BASE_W-1:0]  plus_guide, minus_pam;
   logic [MAX_GUIDE-1:0][1:0]              guide_rc, minus_guide;
   logic [7:0]                             pam_skip, guide_skip;
   logic [6:0]                             win_len;
   logic                                   len_ok;
   logic                                   plus_ok, minus_ok;
   logic [pss_pkg::SITE_BITS_W-1:0]        plus_bits, minus_bits;
   logic [pss_pkg::POS_W-1:0]              plus_pos;

   // Length limits and window fill.
   always_comb begin
      win_len = 7'(guide_len) + 7'(pam_length);
      len_ok  = (guide_len != '0) && (7'(guide_len) <= 7'(MAX_GUIDE)) &&
                (pam_length != '0) && (7'(pam_length) <= 7'(MAX_PAM)) &&
                (7'(fill) >= win_len);
   end

   // Line the window up for each check: newest PAM bases reversed and
   // shifted to PAM order, guide bases behind the PAM, minus PAM behind the
   // protospacer and the complemented protospacer reversed.
   always_comb begin
      pam_skip   = 8'(MAX_PAM) - 8'(pam_length);
      guide_skip = 8'(MAX_GUIDE) - 8'(guide_len);
      for (int q = 0; q < MAX_PAM; q++) begin
         pam_mask[q] = pss_pkg::code_mask(pam_codes[8*q +: 8]);
         pam_rev[q]  = win[MAX_PAM-1-q];
      end
      for (int m = 0; m < MAX_GUIDE; m++) begin
         guide_rc[m] = ~win[MAX_GUIDE-1-m][1:0];
      end
      plus_pam    = pam_rev >> (pam_skip * 8'd3);
      plus_guide  = win >> (7'(pam_length) * 7'd3);
      minus_pam   = win >> (8'(guide_len) * 8'd3);
      minus_guide = guide_rc >> {guide_skip, 1'b0};
   end

   // Plus strand: PAM after the guide, guide made of plain bases.
   always_comb begin
      plus_ok   = len_ok;
      plus_bits = '0;
      for (int q = 0; q < MAX_PAM; q++) begin
         if (pss_pkg::PAM_LEN_W'(q) < pam_length &&
             !pss_pkg::base_in(plus_pam[q], pam_mask[q])) begin
            plus_ok = 1'b0;
         end
      end
      for (int m = 0; m < MAX_GUIDE; m++) begin
         if (pss_pkg::GUIDE_LEN_W'(m) < guide_len) begin
            plus_bits[2*m +: 2] = plus_guide[m][1:0];
            if (plus_guide[m][2]) begin
               plus_ok = 1'b0;
            end
         end
      end
   end

   // Minus strand: complemented PAM in reverse before the protospacer.
   always_comb begin
      minus_ok   = len_ok & scan_minus;
      minus_bits = '0;
      for (int q = 0; q < MAX_PAM; q++) begin
         if (pss_pkg::PAM_LEN_W'(q) < pam_length &&
             !pss_pkg::base_in(minus_pam[q], pss_pkg::comp_mask(pam_mask[q]))) begin
            minus_ok = 1'b0;
         end
      end
      for (int m = 0; m < MAX_GUIDE; m++) begin
         if (pss_pkg::GUIDE_LEN_W'(m) < guide_len) begin
            minus_bits[2*m +: 2] = minus_guide[m];
            if (win[m][2]) begin
               minus_ok = 1'b0;
            end
         end
      end
   end

   // Site start positions.
   assign plus_pos = position - pss_pkg::POS_W'(win_len) + pss_pkg::POS_W'(1);

   assign hits.plus_hit       = plus_ok;
   assign hits.minus_hit      = minus_ok;
   assign plus_site.bits      = plus_bits;
   assign plus_site.seq_id    = seq_id;
   assign plus_site.position  = plus_pos;
   assign minus_site.bits     = minus_bits;
   assign minus_site.seq_id   = seq_id;
   assign minus_site.position = plus_pos + pss_pkg::POS_W'(pam_length);

endmodule

[rtl/core/pss_emit.sv]
// ----------------------------------------------------------------------------
// PAM site scanner result stage
// Holds the plus and minus site of one step and hands them out one per
// transfer, plus strand first.
// ----------------------------------------------------------------------------
module pss_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_valid,
   input  pss_pkg::hits_type  hits,
   input  pss_pkg::site_type  plus_site,
   input  pss_pkg::site_type  minus_site,
   output logic               free,
   pss_rsp_if.source          rsp
);

   logic              plus_pend_ff, plus_pend_in;
   logic              minus_pend_ff, minus_pend_in;
   pss_pkg::site_type plus_data_ff, minus_data_ff;
   logic              rsp_fire;
   logic              load;
   logic              last;

   // Output selection: plus first, last flag when only one remains.
   assign last     = ~(plus_pend_ff & minus_pend_ff);
   assign rsp_fire = rsp.valid & rsp.ready;
   assign free     = ~(plus_pend_ff | minus_pend_ff) | (rsp_fire & last);
   assign load     = step_valid & free;

   assign rsp.valid         = plus_pend_ff | minus_pend_ff;
   assign rsp.minus_strand  = ~plus_pend_ff;
   assign rsp.last_site     = last;
   assign rsp.site_bits     = plus_pend_ff ? plus_data_ff.bits : minus_data_ff.bits;
   assign rsp.site_sequence = plus_pend_ff ? plus_data_ff.seq_id : minus_data_ff.seq_id;
   assign rsp.site_position = plus_pend_ff ? plus_data_ff.position
                                           : minus_data_ff.position;

   // Pending flags: a new step loads both, a transfer retires the shown one.
   always_comb begin
      plus_pend_in  = plus_pend_ff;
      minus_pend_in = minus_pend_ff;
      if (load) begin
         plus_pend_in  = hits.plus_hit;
         minus_pend_in = hits.minus_hit;
      end else if (rsp_fire) begin
         if (plus_pend_ff) begin
            plus_pend_in = 1'b0;
         end else begin
            minus_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_pend_ff  <= 1'b0;
         minus_pend_ff <= 1'b0;
      end else begin
         plus_pend_ff  <= plus_pend_in;
         minus_pend_ff <= minus_pend_in;
      end
   end

   // Site payload.
   always_ff @(posedge clock) begin
      if (load) begin
         plus_data_ff  <= plus_site;
         minus_data_ff <= minus_site;
      end
   end

   // The second site of a pair follows its first.
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp.last_site |=> rsp.valid && rsp.minus_strand)
      else $error("minus site of a pair was lost");

   // A step without a site leaves nothing to send.
   a_empty_step: assert property (@(posedge clock) disable iff (reset)
      load && !hits.plus_hit && !hits.minus_hit |=> !rsp.valid)
      else $error("result shown for a step without a site");

   // Sending the last site with no step waiting empties the stage.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp.last_site && !step_valid |=> !rsp.valid)
      else $error("result repeated after its last transfer");

endmodule

[rtl/core/pam_site_scanner.sv]
// ----------------------------------------------------------------------------
// PAM site scanner
// Streams DNA bases through a guide+PAM window and reports every plus strand
// and (if enabled) minus site whose PAM matches the programmed IUPAC pattern.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one ASCII base per transfer with its sequence id;
//    first_base restarts the position count and window fill.
//  - rsp_if carries found sites: packed guide, sequence id, forward start
//    position and strand. last_site marks the final site of a base.
//  - csr_if writes the guide length, PAM length, PAM codes and the minus
//    strand enable by index; it is always ready. The user must use it only
//    while no base is in flight; the block itself does not enforce this.
//  - A site passes through the window register and then the result
//    register before it is shown.
//  - Throughput: one base per cycle while each base yields at most one site
//    and rsp_if is ready; a base with a plus and a minus site holds the
//    input back, since the result register sends one site per transfer.
//  - Reset clears the window, fill and position and loads the default
//    registers (guide 20, PAM "NGG", both strands).
//  - When rsp_if stalls, the result register holds its sites and one more
//    base waits in the window register; then req_if drops ready.
// ----------------------------------------------------------------------------
module pam_site_scanner #(
   parameter int MAX_GUIDE = pss_pkg::MAX_GUIDE_DEF,
   parameter int MAX_PAM   = pss_pkg::MAX_PAM_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pss_req_if.sink   req_if,
   pss_rsp_if.source rsp_if,
   pss_csr_if.sink   csr_if
);

   localparam int DEPTH  = MAX_GUIDE + MAX_PAM;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [pss_pkg::GUIDE_LEN_W-1:0]       guide_len_ff;
   logic [pss_pkg::PAM_LEN_W-1:0]         pam_length_ff;
   logic [pss_pkg::PAM_CODES_W-1:0]       pam_codes_ff;
   logic                                  scan_minus_ff;
   logic                                  accept;
   logic                                  advance;
   logic                                  step_valid;
   logic                                  free;
   logic [DEPTH-1:0][pss_pkg::BASE_W-1:0] win;
   logic [FILL_W-1:0]                     fill;
   logic [pss_pkg::SEQ_W-1:0]             seq_id;
   logic [pss_pkg::POS_W-1:0]             position;
   pss_pkg::hits_type                     hits;
   pss_pkg::site_type                     plus_site;
   pss_pkg::site_type                     minus_site;

   // Configuration registers.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         guide_len_ff    <= pss_pkg::GUIDE_LEN_RST;
         pam_length_ff   <= pss_pkg::PAM_LENGTH_RST;
         pam_codes_ff    <= pss_pkg::PAM_CODES_RST;
         scan_minus_ff   <= pss_pkg::SCAN_MINUS_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (pss_pkg::csr_index_type'(csr_if.index))
            pss_pkg::CSR_GUIDE_LEN:
               guide_len_ff <= csr_if.data[pss_pkg::GUIDE_LEN_W-1:0];
            pss_pkg::CSR_PAM_LENGTH:
               pam_length_ff <= csr_if.data[pss_pkg::PAM_LEN_W-1:0];
            pss_pkg::CSR_PAM_CODES:
               pam_codes_ff <= csr_if.data;
            pss_pkg::CSR_SCAN_MINUS:
               scan_minus_ff <= csr_if.data[0];
            default: begin
            end
         endcase
      end
   end

   // Flow control: the window register moves on when the result stage frees.
   assign advance      = step_valid & free;
   assign req_if.ready = ~step_valid | free;
   assign accept       = req_if.valid & req_if.ready;

   pss_window #(
      .MAX_GUIDE (MAX_GUIDE),
      .MAX_PAM   (MAX_PAM)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .base_char   (req_if.base_char),
      .first_base  (req_if.first_base),
      .sequence_id (req_if.sequence_id),
      .advance     (advance),
      .step_valid  (step_valid),
      .win         (win),
      .fill        (fill),
      .seq_id      (seq_id),
      .position    (position)
   );

   pss_match #(
      .MAX_GUIDE (MAX_GUIDE),
      .MAX_PAM   (MAX_PAM)
   ) u_match (
      .win          (win),
      .fill         (fill),
      .seq_id       (seq_id),
      .position     (position),
      .guide_len    (guide_len_ff),
      .pam_length   (pam_length_ff),
      .pam_codes    (pam_codes_ff),
      .scan_minus   (scan_minus_ff),
      .hits         (hits),
      .plus_site    (plus_site),
      .minus_site   (minus_site)
   );

   pss_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .hits       (hits),
      .plus_site  (plus_site),
      .minus_site (minus_site),
      .free       (free),
      .rsp        (rsp_if)
   );

endmodule
